// ===== hdl/agcm_pkg.sv =====
// shared constants, types and functions for the aes-128-gcm engine
// aes s-box table, gf(2^8) helpers, byte masking; no dependencies
`timescale 1ns / 1ps
package agcm_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int BUF_AW = $clog2(2 * MAX_BLOCKS);
  localparam int BCNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] OP_AAD = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] KIND_CIPHER = 2'd0;
  localparam logic [1:0] KIND_TAG = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_PLAIN = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW = 3'd1;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd2;
  localparam logic [2:0] REG_NONCE_LOW = 3'd3;
  localparam logic [2:0] REG_OPEN_MODE = 3'd4;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] GHASH_R = 8'he1;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // keep the first cnt bytes of a block, byte 0 in the top bits
  function automatic logic [127:0] keep_bytes(input logic [127:0] blk, input logic [4:0] cnt);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cnt) m[127 - 8 * i -: 8] = 8'hff;
    end
    keep_bytes = blk & m;
  endfunction

endpackage

// ===== hdl/agcm_aes.sv =====
// aes-128 encryption core, one round per cycle with on-the-fly key expansion
// uses agcm_pkg for the s-box and xtime
`timescale 1ns / 1ps
module agcm_aes (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk_in,
  output logic         done,
  output logic [127:0] blk_out
);

  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rc;
  logic [3:0]   rnd;
  logic         busy;

  logic [127:0] rk_next;
  logic [127:0] st_next;
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [31:0]  w;
  logic [31:0]  t;

  always_comb begin
    w = rk[31:0];
    t = {agcm_pkg::SBOX[w[23:16]] ^ rc, agcm_pkg::SBOX[w[15:8]],
         agcm_pkg::SBOX[w[7:0]], agcm_pkg::SBOX[w[31:24]]};
    rk_next[127:96] = rk[127:96] ^ t;
    rk_next[95:64] = rk[95:64] ^ rk_next[127:96];
    rk_next[63:32] = rk[63:32] ^ rk_next[95:64];
    rk_next[31:0] = rk[31:0] ^ rk_next[63:32];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sb[c * 4 + i] = agcm_pkg::SBOX[st[127 - 8 * (((c + i) % 4) * 4 + i) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        mx[c * 4 + i] = sb[c * 4 + i] ^ sb[c * 4] ^ sb[c * 4 + 1] ^ sb[c * 4 + 2]
                      ^ sb[c * 4 + 3]
                      ^ agcm_pkg::xtime(sb[c * 4 + i] ^ sb[c * 4 + (i + 1) % 4]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      st_next[127 - 8 * k -: 8] = ((rnd == 4'd10) ? sb[k] : mx[k]) ^ rk_next[127 - 8 * k -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd <= 4'd1;
        st <= blk_in ^ key;
        rk <= key;
        rc <= agcm_pkg::RCON_FIRST;
      end else if (busy) begin
        st <= st_next;
        rk <= rk_next;
        rc <= agcm_pkg::xtime(rc);
        rnd <= rnd + 4'd1;
        if (rnd == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign blk_out = st;

endmodule

// ===== hdl/agcm_ghash.sv =====
// ghash multiplier in gf(2^128), digit-serial over the subkey, 8 bits per cycle
// uses agcm_pkg for the reduction constant
`timescale 1ns / 1ps
module agcm_ghash (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] x,
  input  logic [127:0] h,
  output logic         done,
  output logic [127:0] z
);

  logic [127:0] v;
  logic [127:0] hs;
  logic [3:0]   cnt;
  logic         busy;
  logic [127:0] v_next;
  logic [127:0] z_next;

  always_comb begin
    v_next = v;
    z_next = z;
    for (int i = 0; i < 8; i++) begin
      if (hs[127 - i]) z_next = z_next ^ v_next;
      v_next = {1'b0, v_next[127:1]} ^
               (v_next[0] ? {agcm_pkg::GHASH_R, 120'd0} : 128'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        v <= x;
        hs <= h;
        z <= '0;
      end else if (busy) begin
        v <= v_next;
        z <= z_next;
        hs <= {hs[119:0], 8'd0};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/aes128_gcm_seal_open.sv =====
// aes-128-gcm seal/open top level: apb registers, stream ports, message sequencer
// aad and open text take a ghash multiply; seal text takes an aes keystream pass, then ghash
// an aes pass makes the subkey on the first item of a message; finish hashes the lengths
// block, then an aes pass gives the tag keystream; op none and empty non-finish are dropped
// ok open finish decrypts buffered blocks by aes passes; one item at a time, no overlap
// reset (rst, synchronous) clears registers and message state; buffer has no clear
`timescale 1ns / 1ps
module aes128_gcm_seal_open (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // in_high, in_low, byte_count
  input  logic [1:0]   s_tuser,  // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,  // out_high, out_low, out_count, status
  output logic [1:0]   m_tuser,  // kind
  output logic         m_tlast   // last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUBKEY = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_KS = 4'd3;
  localparam logic [3:0] S_HASH = 4'd4;
  localparam logic [3:0] S_TAGKS = 4'd5;
  localparam logic [3:0] S_OUT = 4'd6;
  localparam logic [3:0] S_RD = 4'd7;
  localparam logic [3:0] S_RDW = 4'd8;
  localparam logic [3:0] S_PKS = 4'd9;
  localparam logic [3:0] S_POST = 4'd10;

  localparam int BCW = agcm_pkg::BCNT_W;
  localparam int AW = agcm_pkg::BUF_AW;

  logic [63:0] key_high, key_low, nonce_high;
  logic [31:0] nonce_low;
  logic        open_mode;

  logic [3:0]   state;
  logic [1:0]   op;
  logic [127:0] blk;
  logic [4:0]   cnt;
  logic [127:0] hkey;
  logic         subkey_ready;
  logic [127:0] acc;
  logic [31:0]  ctr;
  logic [31:0]  pctr;
  logic [35:0]  aad_bytes, text_bytes;
  logic [BCW-1:0] nbuf;
  logic [BCW-1:0] ridx;
  logic         ovf;
  logic         post_finish;
  logic         ghash_last_fin;

  logic [127:0] mem [agcm_pkg::MAX_BLOCKS];
  logic [127:0] rdata;
  logic         wr_en;

  logic         aes_start, aes_done;
  logic [127:0] aes_in, aes_out;
  logic         aes_kick;
  logic [127:0] aes_kick_in;
  logic         aes_go;
  logic [127:0] aes_go_in;
  logic         gh_start, gh_done;
  logic [127:0] gh_in, gh_out;

  logic [127:0] obuf;
  logic [4:0]   ocnt;
  logic [1:0]   okind, ostat;
  logic         olast;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      nonce_high <= '0;
      nonce_low <= '0;
      open_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        agcm_pkg::REG_KEY_HIGH: key_high <= pwdata;
        agcm_pkg::REG_KEY_LOW: key_low <= pwdata;
        agcm_pkg::REG_NONCE_HIGH: nonce_high <= pwdata;
        agcm_pkg::REG_NONCE_LOW: nonce_low <= pwdata[31:0];
        agcm_pkg::REG_OPEN_MODE: open_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      agcm_pkg::REG_KEY_HIGH: prdata = key_high;
      agcm_pkg::REG_KEY_LOW: prdata = key_low;
      agcm_pkg::REG_NONCE_HIGH: prdata = nonce_high;
      agcm_pkg::REG_NONCE_LOW: prdata = {32'd0, nonce_low};
      agcm_pkg::REG_OPEN_MODE: prdata = {63'd0, open_mode};
      default: prdata = '0;
    endcase
  end

  agcm_aes u_aes (
    .clk(clk), .rst(rst), .start(aes_go), .key({key_high, key_low}),
    .blk_in(aes_go_in), .done(aes_done), .blk_out(aes_out)
  );

  agcm_ghash u_ghash (
    .clk(clk), .rst(rst), .start(gh_start), .x(acc ^ gh_in), .h(hkey),
    .done(gh_done), .z(gh_out)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[nbuf[AW-2:0]] <= agcm_pkg::keep_bytes(blk, cnt);
    rdata <= mem[ridx[AW-2:0]];
  end

  logic [4:0]   s_cnt;
  logic [127:0] tag;
  logic [1:0]   vstat;
  logic [3:0]   tail;

  assign s_cnt = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign tag = aes_out ^ acc;
  assign tail = text_bytes[3:0];
  assign vstat = ovf ? agcm_pkg::ST_OVERFLOW :
                 ((tag != blk) ? agcm_pkg::ST_MISMATCH : agcm_pkg::ST_OK);

  assign m_tdata = {1'b0, ostat, ocnt, obuf[63:0], obuf[127:64]};
  assign m_tuser = okind;
  assign m_tlast = olast;

  always_comb begin
    aes_start = 1'b0;
    aes_in = '0;
    gh_start = 1'b0;
    gh_in = '0;
    wr_en = 1'b0;
    case (state)
      S_DISPATCH: begin
        if (op == agcm_pkg::OP_AAD) begin
          gh_start = 1'b1;
          gh_in = agcm_pkg::keep_bytes(blk, cnt);
        end else if (op == agcm_pkg::OP_TEXT && open_mode) begin
          gh_start = 1'b1;
          gh_in = agcm_pkg::keep_bytes(blk, cnt);
          wr_en = (nbuf < BCW'(agcm_pkg::MAX_BLOCKS));
        end else if (op == agcm_pkg::OP_TEXT) begin
          aes_start = 1'b1;
          aes_in = {nonce_high, nonce_low, ctr};
        end else begin
          gh_start = 1'b1;
          gh_in = {25'd0, aad_bytes, 3'd0, 25'd0, text_bytes, 3'd0};
        end
      end
      S_POST: begin
        gh_start = 1'b1;
        gh_in = blk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      subkey_ready <= 1'b0;
      hkey <= '0;
      acc <= '0;
      ctr <= 32'd2;
      aad_bytes <= '0;
      text_bytes <= '0;
      nbuf <= '0;
      ovf <= 1'b0;
      ridx <= '0;
      post_finish <= 1'b0;
      ghash_last_fin <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= s_tuser;
            blk <= {s_tdata[63:0], s_tdata[127:64]};
            cnt <= s_cnt;
            if (s_tuser != agcm_pkg::OP_NONE &&
                (s_tuser == agcm_pkg::OP_FINISH || s_cnt != 5'd0)) begin
              if (!subkey_ready) begin
                state <= S_SUBKEY;
              end else begin
                state <= S_DISPATCH;
              end
            end
          end
        end
        S_SUBKEY: begin
          if (!subkey_ready) begin
            if (!ghash_last_fin) begin
              ghash_last_fin <= 1'b1;
            end else if (aes_done) begin
              hkey <= aes_out;
              subkey_ready <= 1'b1;
              ghash_last_fin <= 1'b0;
              state <= S_DISPATCH;
            end
          end
        end
        S_DISPATCH: begin
          if (op == agcm_pkg::OP_AAD) begin
            aad_bytes <= aad_bytes + 36'(cnt);
            state <= S_HASH;
          end else if (op == agcm_pkg::OP_TEXT) begin
            text_bytes <= text_bytes + 36'(cnt);
            if (open_mode) begin
              if (nbuf < BCW'(agcm_pkg::MAX_BLOCKS)) nbuf <= nbuf + BCW'(1);
              else ovf <= 1'b1;
              state <= S_HASH;
            end else begin
              state <= S_KS;
            end
          end else begin
            state <= S_HASH;
          end
        end
        S_KS: begin
          if (aes_done) begin
            blk <= agcm_pkg::keep_bytes(blk ^ aes_out, cnt);
            ctr <= ctr + 32'd1;
            state <= S_POST;
          end
        end
        S_POST: begin
          state <= S_HASH;
        end
        S_HASH: begin
          if (gh_done) begin
            acc <= gh_out;
            if (op == agcm_pkg::OP_FINISH) begin
              state <= S_TAGKS;
            end else if (op == agcm_pkg::OP_TEXT && !open_mode) begin
              obuf <= blk;
              ocnt <= cnt;
              okind <= agcm_pkg::KIND_CIPHER;
              ostat <= agcm_pkg::ST_OK;
              olast <= 1'b1;
              m_tvalid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TAGKS: begin
          if (aes_done) begin
            m_tvalid <= 1'b1;
            ostat <= agcm_pkg::ST_OK;
            if (!open_mode) begin
              obuf <= tag;
              ocnt <= 5'd16;
              okind <= agcm_pkg::KIND_TAG;
              olast <= 1'b1;
              post_finish <= 1'b0;
            end else begin
              obuf <= '0;
              ocnt <= 5'd0;
              okind <= agcm_pkg::KIND_VERDICT;
              ostat <= vstat;
              olast <= (vstat != agcm_pkg::ST_OK) || (nbuf == '0);
              post_finish <= (vstat == agcm_pkg::ST_OK) && (nbuf != '0);
            end
            pctr <= ctr;
            ridx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (post_finish) begin
              state <= S_RD;
            end else begin
              state <= S_IDLE;
              if (op == agcm_pkg::OP_FINISH) begin
                subkey_ready <= 1'b0;
                hkey <= '0;
                acc <= '0;
                ctr <= 32'd2;
                aad_bytes <= '0;
                text_bytes <= '0;
                nbuf <= '0;
                ovf <= 1'b0;
              end
            end
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          state <= S_PKS;
        end
        S_PKS: begin
          if (aes_done) begin
            m_tvalid <= 1'b1;
            okind <= agcm_pkg::KIND_PLAIN;
            ostat <= agcm_pkg::ST_OK;
            pctr <= pctr + 32'd1;
            ridx <= ridx + BCW'(1);
            if (ridx + BCW'(1) == nbuf) begin
              ocnt <= (tail == 4'd0) ? 5'd16 : {1'b0, tail};
              obuf <= agcm_pkg::keep_bytes(rdata ^ aes_out,
                                           (tail == 4'd0) ? 5'd16 : {1'b0, tail});
              olast <= 1'b1;
              post_finish <= 1'b0;
            end else begin
              ocnt <= 5'd16;
              obuf <= rdata ^ aes_out;
              olast <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // aes launches for subkey, tag keystream and plaintext keystream
  always_comb begin
    aes_kick = 1'b0;
    aes_kick_in = '0;
    if (state == S_SUBKEY && !ghash_last_fin) aes_kick = 1'b1;
    if (state == S_HASH && gh_done && op == agcm_pkg::OP_FINISH) begin
      aes_kick = 1'b1;
      aes_kick_in = {nonce_high, nonce_low, 32'd1};
    end
    if (state == S_RDW) begin
      aes_kick = 1'b1;
      aes_kick_in = {nonce_high, nonce_low, pctr};
    end
  end

  assign aes_go = aes_start | aes_kick;
  assign aes_go_in = aes_start ? aes_in : aes_kick_in;

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_IDLE)) else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    nbuf <= BCW'(agcm_pkg::MAX_BLOCKS)) else $error("buffer count past limit");

endmodule
